[rtl/page_header_validator_unit_macros.svh]
// assertion macros for the page header validator
`ifndef PAGE_HEADER_VALIDATOR_UNIT_MACROS_SVH
`define PAGE_HEADER_VALIDATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PHV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("phv assertion failed");
`define PHV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("phv assertion failed");
`else
`define PHV_ASSERT(lbl, clk, rstn, prop)
`define PHV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/phv_pkg.sv]
// shared types, constants and functions of the page header validator
`default_nettype none

package phv_pkg;

    localparam logic [6:0]  HDR_LEN   = 7'd88;
    localparam logic [6:0]  POS_LAST  = 7'd87;
    localparam logic [6:0]  CRC_END   = 7'd84;
    localparam logic [6:0]  POS_QUOT  = 7'd76;
    localparam logic [6:0]  POS_BOUND = 7'd77;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [31:0] BOUND_LIMIT = 32'd2113929216;
    localparam logic [31:0] RECIP_255 = 32'h80808081;
    localparam logic [15:0] HDR_LEN_WORD = 16'd88;
    localparam logic [7:0]  COMP_CODE = 8'd1;

    localparam logic [2:0] CFG_SCHEMA   = 3'd0;
    localparam logic [2:0] CFG_EDGE     = 3'd1;
    localparam logic [2:0] CFG_MAX_PAY  = 3'd2;
    localparam logic [2:0] CFG_MAX_QUAL = 3'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNC     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_SCHEMA    = 3'd3,
        ST_QUALITY   = 3'd4,
        ST_ENCODING  = 3'd5,
        ST_HDR_CHECK = 3'd6,
        ST_CSIZE     = 3'd7
    } t_status;

    typedef struct packed {
        logic [15:0] schema_version;
        logic [15:0] page_edge;
        logic [30:0] max_payload_bytes;
        logic [7:0]  max_quality;
    } t_cfg;

    typedef struct packed {
        logic        magic_ok;
        logic [15:0] schema;
        logic [15:0] hdr_len;
        logic [7:0]  comp;
        logic [7:0]  quality;
        logic [15:0] revision;
        logic [63:0] page_x;
        logic [63:0] page_z;
        logic [63:0] seed;
        logic [15:0] edge_len;
        logic [15:0] rsvd;
        logic [31:0] pay_len;
        logic [31:0] cmp_len;
        logic [31:0] pay_crc;
        logic [23:0] hcrc_lo;
        logic [31:0] crc_final;
        logic [32:0] bound;
    } t_hdr;

    typedef struct packed {
        t_status     status;
        logic [7:0]  quality;
        logic [15:0] revision;
        logic [63:0] page_x;
        logic [63:0] page_z;
        logic [63:0] world_seed;
        logic [31:0] payload_length;
        logic [31:0] compressed_length;
        logic [31:0] payload_crc;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h52;
            2'd2:    m = 8'h48;
            default: m = 8'h59;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/phv_if.sv]
// valid/ready channel interfaces for input bytes and header results
`default_nettype none

interface phv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phv_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         quality;
    logic [15:0]        revision;
    logic signed [63:0] page_x;
    logic signed [63:0] page_z;
    logic [63:0]        world_seed;
    logic [31:0]        payload_length;
    logic [31:0]        compressed_length;
    logic [31:0]        payload_crc;

    modport source (
        output valid, output status, output quality, output revision,
        output page_x, output page_z, output world_seed, output payload_length,
        output compressed_length, output payload_crc, input ready
    );
    modport sink (
        input valid, input status, input quality, input revision,
        input page_x, input page_z, input world_seed, input payload_length,
        input compressed_length, input payload_crc, output ready
    );
endinterface

`default_nettype wire

[rtl/phv_hdr_parse.sv]
// byte position tracking, header field capture, crc and size bound
`default_nettype none
`include "page_header_validator_unit_macros.svh"

module phv_hdr_parse (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output phv_pkg::t_hdr    o_hdr,
    output logic             o_done,
    output logic             o_pos_last
);

    logic [6:0]  r_pos;
    logic        r_done;
    logic        r_magic_ok;
    logic [31:0] r_crc;
    logic [15:0] r_schema, r_hdr_len, r_rev, r_edge, r_rsvd;
    logic [7:0]  r_comp, r_qual;
    logic [63:0] r_page_x, r_page_z, r_seed;
    logic [31:0] r_pay, r_cmp, r_pcrc;
    logic [23:0] r_hcrc_lo;
    logic [24:0] r_quot;
    logic [32:0] r_bound;

    logic        w_step;
    logic [6:0]  w_woff, w_loff;
    logic [63:0] w_prod;

    assign w_step = i_take && !r_done;
    assign w_woff = r_pos - 7'd12;
    assign w_loff = r_pos - 7'd72;
    assign w_prod = r_pay * phv_pkg::RECIP_255;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_done     <= 1'b0;
            r_magic_ok <= 1'b1;
            r_crc      <= phv_pkg::CRC_INIT;
        end else if (i_take) begin
            if (i_last) begin
                r_pos      <= '0;
                r_done     <= 1'b0;
                r_magic_ok <= 1'b1;
                r_crc      <= phv_pkg::CRC_INIT;
            end else if (!r_done) begin
                r_pos  <= r_pos + 7'd1;
                r_done <= (r_pos == phv_pkg::POS_LAST);
                if (r_pos < phv_pkg::CRC_END) begin
                    r_crc <= phv_pkg::crc_byte(r_crc, i_byte);
                end
                if (r_pos < 7'd4 && i_byte != phv_pkg::magic_byte(r_pos[1:0])) begin
                    r_magic_ok <= 1'b0;
                end
            end
        end
    end

    // field capture, each byte lands once per header
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            case (r_pos)
                7'd4:  r_schema[7:0]   <= i_byte;
                7'd5:  r_schema[15:8]  <= i_byte;
                7'd6:  r_hdr_len[7:0]  <= i_byte;
                7'd7:  r_hdr_len[15:8] <= i_byte;
                7'd8:  r_comp          <= i_byte;
                7'd9:  r_qual          <= i_byte;
                7'd10: r_rev[7:0]      <= i_byte;
                7'd11: r_rev[15:8]     <= i_byte;
                7'd68: r_edge[7:0]     <= i_byte;
                7'd69: r_edge[15:8]    <= i_byte;
                7'd70: r_rsvd[7:0]     <= i_byte;
                7'd71: r_rsvd[15:8]    <= i_byte;
                default: ;
            endcase
            if (r_pos >= 7'd12 && r_pos < 7'd36) begin
                case (w_woff[4:3])
                    2'd0:    r_page_x[{w_woff[2:0], 3'b000} +: 8] <= i_byte;
                    2'd1:    r_page_z[{w_woff[2:0], 3'b000} +: 8] <= i_byte;
                    default: r_seed[{w_woff[2:0], 3'b000} +: 8]   <= i_byte;
                endcase
            end
            if (r_pos >= 7'd72 && r_pos < phv_pkg::POS_LAST) begin
                case (w_loff[3:2])
                    2'd0:    r_pay[{w_loff[1:0], 3'b000} +: 8]  <= i_byte;
                    2'd1:    r_cmp[{w_loff[1:0], 3'b000} +: 8]  <= i_byte;
                    2'd2:    r_pcrc[{w_loff[1:0], 3'b000} +: 8] <= i_byte;
                    default: r_hcrc_lo[{w_loff[1:0], 3'b000} +: 8] <= i_byte;
                endcase
            end
            // payload / 255 then the lz4 bound, while the tail bytes stream in
            if (r_pos == phv_pkg::POS_QUOT) begin
                r_quot <= w_prod[63:39];
            end
            if (r_pos == phv_pkg::POS_BOUND) begin
                r_bound <= {1'b0, r_pay} + {8'd0, r_quot} + 33'd16;
            end
        end
    end

    always_comb begin
        o_hdr.magic_ok  = r_magic_ok;
        o_hdr.schema    = r_schema;
        o_hdr.hdr_len   = r_hdr_len;
        o_hdr.comp      = r_comp;
        o_hdr.quality   = r_qual;
        o_hdr.revision  = r_rev;
        o_hdr.page_x    = r_page_x;
        o_hdr.page_z    = r_page_z;
        o_hdr.seed      = r_seed;
        o_hdr.edge_len  = r_edge;
        o_hdr.rsvd      = r_rsvd;
        o_hdr.pay_len   = r_pay;
        o_hdr.cmp_len   = r_cmp;
        o_hdr.pay_crc   = r_pcrc;
        o_hdr.hcrc_lo   = r_hcrc_lo;
        o_hdr.crc_final = ~r_crc;
        o_hdr.bound     = r_bound;
    end

    assign o_done     = r_done;
    assign o_pos_last = (r_pos == phv_pkg::POS_LAST);

    `PHV_ASSERT(a_done_pos, i_clk, i_rst_n, r_done |-> (r_pos == phv_pkg::HDR_LEN))
    `PHV_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_take && i_last, r_pos == '0 && !r_done && r_magic_ok)
    `PHV_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, w_step && !i_last, r_pos == $past(r_pos) + 7'd1)

endmodule

`default_nettype wire

[rtl/phv_hdr_check.sv]
// header checks in fixed priority order, gives the result status
`default_nettype none

module phv_hdr_check (
    input  wire phv_pkg::t_hdr i_hdr,
    input  wire logic [7:0]    i_byte,
    input  wire phv_pkg::t_cfg i_cfg,
    output phv_pkg::t_status   o_status
);

    logic [31:0] w_hcrc;
    logic        w_bad_schema, w_bad_qual, w_bad_enc, w_bad_hdr, w_bad_size;

    assign w_hcrc = {i_byte, i_hdr.hcrc_lo};

    assign w_bad_schema = (i_hdr.schema != i_cfg.schema_version)
                       || (i_hdr.hdr_len != phv_pkg::HDR_LEN_WORD);
    assign w_bad_qual   = (i_hdr.quality > i_cfg.max_quality);
    assign w_bad_enc    = (i_hdr.comp != phv_pkg::COMP_CODE) || (i_hdr.revision == '0);
    assign w_bad_hdr    = (i_hdr.edge_len != i_cfg.page_edge) || (i_hdr.rsvd != '0)
                       || (i_hdr.pay_len == '0)
                       || (i_hdr.pay_len > {1'b0, i_cfg.max_payload_bytes})
                       || (i_hdr.cmp_len == '0) || (w_hcrc != i_hdr.crc_final);
    assign w_bad_size   = (i_hdr.pay_len > phv_pkg::BOUND_LIMIT)
                       || ({1'b0, i_hdr.cmp_len} > i_hdr.bound);

    always_comb begin
        if (!i_hdr.magic_ok) begin
            o_status = phv_pkg::ST_MAGIC;
        end else if (w_bad_schema) begin
            o_status = phv_pkg::ST_SCHEMA;
        end else if (w_bad_qual) begin
            o_status = phv_pkg::ST_QUALITY;
        end else if (w_bad_enc) begin
            o_status = phv_pkg::ST_ENCODING;
        end else if (w_bad_hdr) begin
            o_status = phv_pkg::ST_HDR_CHECK;
        end else if (w_bad_size) begin
            o_status = phv_pkg::ST_CSIZE;
        end else begin
            o_status = phv_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

[rtl/page_header_validator_unit.sv]
// Page header validator top level. Takes a page file one byte per item on
// i_in and gives one result on o_out when the 88-byte header is complete,
// or a truncated status if last_byte comes earlier; bytes after the header
// are dropped until last_byte. One byte is taken every cycle while o_out is
// not stalled: a byte sits in an input register, is folded into the header
// state and crc, and on the final header byte the checks run and the result
// is registered for o_out. A result waiting on o_out holds the input
// register, and i_in stalls once that register is full. The payload/255
// division for the size bound runs on the two bytes after the payload
// length field. Configuration writes go through i_cfg_we/i_cfg_idx and
// should only be made while no file is in flight.
`default_nettype none
`include "page_header_validator_unit_macros.svh"

module page_header_validator_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    phv_in_if.sink            i_in,
    phv_out_if.source         o_out,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [30:0]  i_cfg_data
);

    phv_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_valid, n_out_valid;
    phv_pkg::t_result r_out, n_out;

    phv_pkg::t_hdr    w_hdr;
    phv_pkg::t_status w_status;
    logic             w_done, w_pos_last;
    logic             w_advance, w_take, w_has_res;
    logic             w_trunc_out, w_trunc_ok;

    assign w_advance = !r_out_valid || o_out.ready;
    assign w_take    = r_in_valid && w_advance;
    assign w_has_res = !w_done && (w_pos_last || r_in_last);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.schema_version    <= 16'd1;
            r_cfg.page_edge         <= 16'd64;
            r_cfg.max_payload_bytes <= 31'd1048576;
            r_cfg.max_quality       <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                phv_pkg::CFG_SCHEMA:   r_cfg.schema_version    <= i_cfg_data[15:0];
                phv_pkg::CFG_EDGE:     r_cfg.page_edge         <= i_cfg_data[15:0];
                phv_pkg::CFG_MAX_PAY:  r_cfg.max_payload_bytes <= i_cfg_data;
                phv_pkg::CFG_MAX_QUAL: r_cfg.max_quality       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    phv_hdr_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_hdr      (w_hdr),
        .o_done     (w_done),
        .o_pos_last (w_pos_last)
    );

    phv_hdr_check u_check (
        .i_hdr    (w_hdr),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_status (w_status)
    );

    always_comb begin
        if (w_pos_last) begin
            n_out.status            = w_status;
            n_out.quality           = w_hdr.quality;
            n_out.revision          = w_hdr.revision;
            n_out.page_x            = w_hdr.page_x;
            n_out.page_z            = w_hdr.page_z;
            n_out.world_seed        = w_hdr.seed;
            n_out.payload_length    = w_hdr.pay_len;
            n_out.compressed_length = w_hdr.cmp_len;
            n_out.payload_crc       = w_hdr.pay_crc;
        end else begin
            n_out        = '0;
            n_out.status = phv_pkg::ST_TRUNC;
        end
    end

    always_comb begin
        if (w_take) begin
            n_out_valid = w_has_res;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_has_res) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_out.status;
    assign o_out.quality           = r_out.quality;
    assign o_out.revision          = r_out.revision;
    assign o_out.page_x            = r_out.page_x;
    assign o_out.page_z            = r_out.page_z;
    assign o_out.world_seed        = r_out.world_seed;
    assign o_out.payload_length    = r_out.payload_length;
    assign o_out.compressed_length = r_out.compressed_length;
    assign o_out.payload_crc       = r_out.payload_crc;

    assign w_trunc_out = r_out_valid && (r_out.status == phv_pkg::ST_TRUNC);
    assign w_trunc_ok  = (r_out.payload_length == '0) && (r_out.world_seed == '0)
                      && (r_out.quality == '0);

    `PHV_ASSERT(a_ready_stall, i_clk, i_rst_n, !i_in.ready |-> (r_in_valid && r_out_valid))
    `PHV_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, w_take && w_has_res, r_out_valid)
    `PHV_ASSERT(a_trunc_zero, i_clk, i_rst_n, w_trunc_out |-> w_trunc_ok)

endmodule

`default_nettype wire
